// File: rtl/nrmp_pkg.sv
// ----------------------------------------------------------------------------
// nrmp_pkg
// Shared types and constants of the 9P2000.L reply message parser.
// ----------------------------------------------------------------------------
package nrmp_pkg;

    // Header length in bytes: size u32, type u8, tag u16.
    localparam logic [31:0] HDR_LEN      = 32'd7;
    localparam logic [31:0] POSITION_MAX = 32'hFFFF_FFFF;

    // Supported reply type numbers.
    localparam logic [7:0] T_RLERROR  = 8'd7;
    localparam logic [7:0] T_RLOPEN   = 8'd13;
    localparam logic [7:0] T_RLCREATE = 8'd15;
    localparam logic [7:0] T_RVERSION = 8'd101;
    localparam logic [7:0] T_RATTACH  = 8'd105;
    localparam logic [7:0] T_RWALK    = 8'd111;
    localparam logic [7:0] T_RREAD    = 8'd117;
    localparam logic [7:0] T_RWRITE   = 8'd119;
    localparam logic [7:0] T_RCLUNK   = 8'd121;

    // Result field kinds.
    localparam logic [3:0] FK_TAG      = 4'd0;
    localparam logic [3:0] FK_MSIZE    = 4'd1;
    localparam logic [3:0] FK_STRLEN   = 4'd2;
    localparam logic [3:0] FK_STRBYTE  = 4'd3;
    localparam logic [3:0] FK_QIDTYPE  = 4'd4;
    localparam logic [3:0] FK_QIDVER   = 4'd5;
    localparam logic [3:0] FK_QIDPATH  = 4'd6;
    localparam logic [3:0] FK_NWQID    = 4'd7;
    localparam logic [3:0] FK_IOUNIT   = 4'd8;
    localparam logic [3:0] FK_ECODE    = 4'd9;
    localparam logic [3:0] FK_COUNT    = 4'd10;
    localparam logic [3:0] FK_DATABYTE = 4'd11;
    localparam logic [3:0] FK_END      = 4'd12;

    // End-of-message status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
    localparam logic [2:0] ST_SIZE        = 3'd2;
    localparam logic [2:0] ST_WRONG_TYPE  = 3'd3;
    localparam logic [2:0] ST_BODY_LEN    = 3'd4;
    localparam logic [2:0] ST_OVER_CAP    = 3'd5;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd6;

    // Configuration register indexes.
    localparam logic [0:0] CFG_WALK_QID_CAP  = 1'b0;
    localparam logic [0:0] CFG_READ_DATA_CAP = 1'b1;

    // Result queue geometry.
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = 2;
    localparam int unsigned RES_CNT_W = 3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_end;
        logic [7:0] awaited_type;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [63:0] field_value;
        logic [2:0]  end_status;
        logic        last_result;
    } out_item_t;

    // Results produced by one accepted byte, in order.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } res_push_t;

endpackage

// File: rtl/nrmp_parser.sv
// ----------------------------------------------------------------------------
// nrmp_parser
// Frame state registers and the per-byte header and body decode step.
// ----------------------------------------------------------------------------
module nrmp_parser
    import nrmp_pkg::*;
#(
    parameter int unsigned MAX_WALK_ELEMENTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_item_t    item,
    input  logic [4:0]  walk_qid_cap,
    input  logic [31:0] read_data_cap,
    output res_push_t   push
);

    typedef enum logic [3:0] {
        PH_HDR      = 4'd0,
        PH_MSIZE    = 4'd1,
        PH_STRLEN   = 4'd2,
        PH_STRBYTES = 4'd3,
        PH_QTYPE    = 4'd4,
        PH_QVER     = 4'd5,
        PH_QPATH    = 4'd6,
        PH_NWQID    = 4'd7,
        PH_IOUNIT   = 4'd8,
        PH_ECODE    = 4'd9,
        PH_COUNT    = 4'd10,
        PH_DATA     = 4'd11,
        PH_WCOUNT   = 4'd12,
        PH_DONE     = 4'd13,
        PH_SKIP     = 4'd14
    } phase_t;

    function automatic phase_t body_start(input logic [7:0] t);
        phase_t p;
        p = PH_SKIP;
        priority if (t == T_RVERSION) p = PH_MSIZE;
        else if (t == T_RATTACH)      p = PH_QTYPE;
        else if (t == T_RWALK)        p = PH_NWQID;
        else if (t == T_RCLUNK)       p = PH_DONE;
        else if (t == T_RLERROR)      p = PH_ECODE;
        else if (t == T_RLOPEN)       p = PH_QTYPE;
        else if (t == T_RLCREATE)     p = PH_QTYPE;
        else if (t == T_RREAD)        p = PH_COUNT;
        else if (t == T_RWRITE)       p = PH_WCOUNT;
        else                          p = PH_SKIP;
        return p;
    endfunction

    localparam logic [15:0] WALK_MAX = 16'(MAX_WALK_ELEMENTS);

    logic [31:0] pos_reg,    pos_next;
    logic [31:0] size_reg,   size_next;
    logic [7:0]  type_reg,   type_next;
    logic [7:0]  wanted_reg, wanted_next;
    logic [63:0] acc_reg,    acc_next;
    phase_t      phase_reg,  phase_next;
    logic [31:0] rem_reg,    rem_next;
    logic [2:0]  err_reg,    err_next;
    logic [2:0]  fb_reg,     fb_next;

    logic [63:0] gather_acc;
    logic [2:0]  gather_last;
    logic        gather_done;
    logic        gathering;
    logic [31:0] rem_dec;
    logic        field_valid;
    out_item_t   field_res;
    out_item_t   end_res;
    logic [2:0]  status;

    always_comb
    begin
        gather_acc = acc_reg | (64'(item.byte_value) << {fb_reg, 3'b000});
        rem_dec    = (rem_reg != 32'd0) ? rem_reg - 32'd1 : 32'd0;
        unique case (phase_reg)
            PH_STRLEN, PH_NWQID:
            begin
                gathering   = 1'b1;
                gather_last = 3'd1;
            end
            PH_QPATH:
            begin
                gathering   = 1'b1;
                gather_last = 3'd7;
            end
            PH_MSIZE, PH_QVER, PH_IOUNIT, PH_ECODE, PH_COUNT, PH_WCOUNT:
            begin
                gathering   = 1'b1;
                gather_last = 3'd3;
            end
            default:
            begin
                gathering   = 1'b0;
                gather_last = 3'd0;
            end
        endcase
        gather_done = (fb_reg == gather_last);
    end

    always_comb
    begin
        pos_next    = (pos_reg == POSITION_MAX) ? pos_reg : pos_reg + 32'd1;
        size_next   = size_reg;
        type_next   = type_reg;
        wanted_next = (pos_reg == 32'd0) ? item.awaited_type : wanted_reg;
        acc_next    = acc_reg;
        phase_next  = phase_reg;
        rem_next    = rem_reg;
        err_next    = err_reg;
        fb_next     = fb_reg;
        field_valid = 1'b0;
        field_res   = '0;

        if (pos_reg < HDR_LEN)
        begin
            priority if (pos_reg < 32'd4)
            begin
                size_next = size_reg | (32'(item.byte_value) << {pos_reg[1:0], 3'b000});
            end
            else if (pos_reg == 32'd4)
            begin
                type_next = item.byte_value;
            end
            else if (pos_reg == 32'd5)
            begin
                acc_next = 64'(item.byte_value);
            end
            else
            begin
                field_valid           = 1'b1;
                field_res.field_kind  = FK_TAG;
                field_res.field_value = acc_reg | (64'(item.byte_value) << 8);
                acc_next              = '0;
                fb_next               = '0;
                phase_next = (type_reg != wanted_next) ? PH_SKIP : body_start(type_reg);
            end
        end
        else
        begin
            if (gathering)
            begin
                acc_next = gather_done ? 64'd0 : gather_acc;
                fb_next  = gather_done ? 3'd0 : fb_reg + 3'd1;
            end
            unique case (phase_reg)
                PH_MSIZE:
                begin
                    if (gather_done)
                    begin
                        field_valid           = 1'b1;
                        field_res.field_kind  = FK_MSIZE;
                        field_res.field_value = gather_acc;
                        phase_next            = PH_STRLEN;
                    end
                end
                PH_STRLEN:
                begin
                    if (gather_done)
                    begin
                        field_valid           = 1'b1;
                        field_res.field_kind  = FK_STRLEN;
                        field_res.field_value = gather_acc;
                        rem_next              = gather_acc[31:0];
                        phase_next = (gather_acc[31:0] != 32'd0) ? PH_STRBYTES : PH_DONE;
                    end
                end
                PH_STRBYTES, PH_DATA:
                begin
                    field_valid           = 1'b1;
                    field_res.field_kind  = (phase_reg == PH_DATA) ? FK_DATABYTE : FK_STRBYTE;
                    field_res.field_value = 64'(item.byte_value);
                    rem_next              = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_QTYPE:
                begin
                    field_valid           = 1'b1;
                    field_res.field_kind  = FK_QIDTYPE;
                    field_res.field_value = 64'(item.byte_value);
                    acc_next              = '0;
                    fb_next               = '0;
                    phase_next            = PH_QVER;
                end
                PH_QVER:
                begin
                    if (gather_done)
                    begin
                        field_valid           = 1'b1;
                        field_res.field_kind  = FK_QIDVER;
                        field_res.field_value = gather_acc;
                        phase_next            = PH_QPATH;
                    end
                end
                PH_QPATH:
                begin
                    if (gather_done)
                    begin
                        field_valid           = 1'b1;
                        field_res.field_kind  = FK_QIDPATH;
                        field_res.field_value = gather_acc;
                        priority if (type_reg == T_RWALK)
                        begin
                            rem_next   = rem_dec;
                            phase_next = (rem_dec != 32'd0) ? PH_QTYPE : PH_DONE;
                        end
                        else if (type_reg == T_RATTACH)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_IOUNIT;
                        end
                    end
                end
                PH_NWQID:
                begin
                    if (gather_done)
                    begin
                        field_valid           = 1'b1;
                        field_res.field_kind  = FK_NWQID;
                        field_res.field_value = gather_acc;
                        if (gather_acc[15:0] > {11'd0, walk_qid_cap} ||
                            gather_acc[15:0] > WALK_MAX)
                        begin
                            if (err_reg == ST_OK)
                            begin
                                err_next = ST_OVER_CAP;
                            end
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            rem_next   = 32'(gather_acc[15:0]);
                            phase_next = (gather_acc[15:0] != 16'd0) ? PH_QTYPE : PH_DONE;
                        end
                    end
                end
                PH_IOUNIT, PH_ECODE, PH_WCOUNT:
                begin
                    if (gather_done)
                    begin
                        field_valid           = 1'b1;
                        field_res.field_kind  = (phase_reg == PH_IOUNIT) ? FK_IOUNIT :
                                                (phase_reg == PH_ECODE) ? FK_ECODE : FK_COUNT;
                        field_res.field_value = gather_acc;
                        phase_next            = PH_DONE;
                    end
                end
                PH_COUNT:
                begin
                    if (gather_done)
                    begin
                        field_valid           = 1'b1;
                        field_res.field_kind  = FK_COUNT;
                        field_res.field_value = gather_acc;
                        if (gather_acc[31:0] > read_data_cap)
                        begin
                            if (err_reg == ST_OK)
                            begin
                                err_next = ST_OVER_CAP;
                            end
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            rem_next   = gather_acc[31:0];
                            phase_next = (gather_acc[31:0] != 32'd0) ? PH_DATA : PH_DONE;
                        end
                    end
                end
                PH_DONE:
                begin
                    if (err_reg == ST_OK)
                    begin
                        err_next = ST_BODY_LEN;
                    end
                    phase_next = PH_SKIP;
                end
                default:
                begin
                end
            endcase
        end

        // Status of the whole message, from the state after this byte.
        priority if (pos_next < HDR_LEN)
            status = ST_SHORT_HDR;
        else if (pos_next == POSITION_MAX || size_next != pos_next)
            status = ST_SIZE;
        else if (type_next != wanted_next)
            status = ST_WRONG_TYPE;
        else if (body_start(type_next) == PH_SKIP)
            status = ST_UNSUPPORTED;
        else if (err_next != ST_OK)
            status = err_next;
        else if (phase_next != PH_DONE)
            status = ST_BODY_LEN;
        else
            status = ST_OK;

        end_res             = '0;
        end_res.field_kind  = FK_END;
        end_res.end_status  = status;
        end_res.last_result = 1'b1;

        push = '0;
        if (step)
        begin
            if (field_valid)
            begin
                push.first  = field_res;
                push.second = end_res;
                push.count  = item.frame_end ? 2'd2 : 2'd1;
            end
            else if (item.frame_end)
            begin
                push.first = end_res;
                push.count = 2'd1;
            end
        end

        // The end of a frame returns all frame state to its reset value.
        if (item.frame_end)
        begin
            pos_next    = '0;
            size_next   = '0;
            type_next   = '0;
            wanted_next = '0;
            acc_next    = '0;
            phase_next  = PH_HDR;
            rem_next    = '0;
            err_next    = ST_OK;
            fb_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            size_reg   <= '0;
            type_reg   <= '0;
            wanted_reg <= '0;
            acc_reg    <= '0;
            phase_reg  <= PH_HDR;
            rem_reg    <= '0;
            err_reg    <= ST_OK;
            fb_reg     <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            size_reg   <= size_next;
            type_reg   <= type_next;
            wanted_reg <= wanted_next;
            acc_reg    <= acc_next;
            phase_reg  <= phase_next;
            rem_reg    <= rem_next;
            err_reg    <= err_next;
            fb_reg     <= fb_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.frame_end |=> pos_reg == 32'd0 && phase_reg == PH_HDR)
        else $error("frame state not cleared after the last byte");

    a_pair_ends: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.second.last_result && !push.first.last_result)
        else $error("two results without the end result second");

    a_push_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> step)
        else $error("results produced without an accepted item");

    a_err_skips: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK |-> phase_reg == PH_SKIP)
        else $error("body error recorded while still decoding");

endmodule

// File: rtl/nrmp_result_fifo.sv
// ----------------------------------------------------------------------------
// nrmp_result_fifo
// Small result queue that takes up to two results a cycle and gives one while the reader is ready.
// ----------------------------------------------------------------------------
module nrmp_result_fifo
    import nrmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_push_t push,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    out_item_t            mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] count_next;
    logic                 pop;

    // Room for the two results that one item may cause.
    assign space     = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count_next = count_reg + RES_CNT_W'(push.count) - RES_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + RES_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> space)
        else $error("results pushed without room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - RES_CNT_W'(1))
        else $error("queue count wrong after a pop");

endmodule

// File: rtl/ninep_r_message_parser.sv
// ----------------------------------------------------------------------------
// ninep_r_message_parser
// Byte-stream decoder for 9P2000.L reply messages with header checks.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  in        input      in_valid / in_ready        in_item  (in_item_t)
//  out       output     out_valid / out_ready      out_item (out_item_t)
//  cfg       input      cfg_write, cfg_index       cfg_data (32 bits)
//
// One byte item is taken per clock cycle while the queue has room for two
// results. Its decode is done in the same cycle and its results (a field,
// the end status, or both) land in a four-entry result queue, so they are
// registered before they reach the output. The queue's single read port
// sets the rate: one result leaves per cycle while out_ready is high, so
// the two results of a byte leave one after the other. Reset clears the
// frame state and restores walk_qid_cap to 16 and read_data_cap to all
// ones. A stalled output holds the queue and, once it lacks room, the input.
//
module ninep_r_message_parser
    import nrmp_pkg::*;
#(
    parameter int unsigned MAX_WALK_ELEMENTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [4:0]  walk_qid_cap_reg;
    logic [31:0] read_data_cap_reg;
    logic        step;
    logic        space;
    res_push_t   push;

    // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_qid_cap_reg  <= 5'd16;
            read_data_cap_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WALK_QID_CAP:  walk_qid_cap_reg  <= cfg_data[4:0];
                CFG_READ_DATA_CAP: read_data_cap_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // An item is accepted whenever the queue can hold everything it causes.
    assign in_ready = space;
    assign step     = in_valid && in_ready;

    // The parser holds the frame state and decodes one byte per accepted item.
    nrmp_parser #(
        .MAX_WALK_ELEMENTS (MAX_WALK_ELEMENTS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (in_item),
        .walk_qid_cap  (walk_qid_cap_reg),
        .read_data_cap (read_data_cap_reg),
        .push          (push)
    );

    // The result queue separates the decode from output stalls.
    nrmp_result_fifo u_results (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
